[rtl/sha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned RoundCount = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       load_iv;     // hash words to initial values
    logic       write_byte;  // write data into block buffer at fill
    logic [7:0] wr_data;
    logic [5:0] wr_addr;
    logic       start_comp;  // run one compression over the buffer
    logic       shift_out;   // rotate hash words for output
  } dp_cmd_t;

  typedef struct packed {
    logic comp_busy;
    logic comp_done;
  } dp_stat_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [0:63];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/sha_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_datapath
// block buffer memory, message schedule window and round datapath
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::dp_cmd_t cmd,
  output sha_pkg::dp_stat_t stat,
  output sha_pkg::word_t   head_word
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_LOAD  = 4'b0010,
    C_ROUND = 4'b0100,
    C_ADD   = 4'b1000
  } comp_state_t;

  logic [7:0]  buffer [0:63];
  logic [7:0]  rd_data;
  logic [5:0]  rd_addr;
  comp_state_t state;
  logic [6:0]  cnt;
  word_t       hash [0:7];
  word_t       v [0:7];
  word_t       w [0:15];
  word_t       pack;
  word_t       load_word;
  word_t       w_new, w_cur, s0, s1, sum0, sum1, ch, maj, x1;

  // byte read address runs ahead by one for the registered read
  assign rd_addr = cnt[5:0];

  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      buffer[cmd.wr_addr] <= cmd.wr_data;
    end
    rd_data <= buffer[rd_addr];
  end

  assign s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign w_new = s1 + w[9] + s0 + w[0];
  assign w_cur = w[0];
  assign sum1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign sum0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign x1    = v[7] + sum1 + ch + round_k(cnt[5:0]) + w_cur;
  assign load_word = {pack[23:0], rd_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= iv_word(3'(i));
    end else begin
      unique case (state)
        C_IDLE: begin
          if (cmd.load_iv) begin
            for (int i = 0; i < 8; i++) hash[i] <= iv_word(3'(i));
          end else if (cmd.shift_out) begin
            for (int i = 0; i < 7; i++) hash[i] <= hash[i + 1];
            hash[7] <= hash[0];
          end
          if (cmd.start_comp) begin
            state <= C_LOAD;
            cnt   <= 7'd1;
          end
        end
        C_LOAD: begin
          // byte cnt-1 is on rd_data; bytes pack big-endian into a word
          pack <= load_word;
          if (cnt[1:0] == 2'd0) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
            w[15] <= load_word;
          end
          if (cnt == 7'd64) begin
            state <= C_ROUND;
            cnt   <= '0;
            for (int i = 0; i < 8; i++) v[i] <= hash[i];
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        C_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
          v[4] <= v[3] + x1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
          v[0] <= x1 + sum0 + maj;
          if (cnt == 7'd63) begin
            state <= C_ADD;
          end
          cnt <= cnt + 7'd1;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
          state <= C_IDLE;
          cnt   <= '0;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign stat.comp_busy = (state != C_IDLE);
  assign stat.comp_done = (state == C_ADD);
  assign head_word      = hash[0];

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start_comp |-> state == C_IDLE) else $error("compression started while busy");
  a_round_len: assert property (@(posedge clk) disable iff (rst)
    state == C_ADD |-> $past(state) == C_ROUND && $past(cnt) == 7'd63)
    else $error("round count broken");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    state != C_IDLE |-> !cmd.write_byte) else $error("buffer written during compression");

endmodule

[rtl/sha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ctrl
// handshake, fill and length tracking, padding sequencer and digest output
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              ready,
  input  logic [7:0]        data_byte,
  input  logic              byte_present,
  input  logic              end_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        word_index,
  output logic              last_word,
  output sha_pkg::dp_cmd_t  cmd,
  input  sha_pkg::dp_stat_t stat
);
  import sha_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_WAIT   = 7'b0000010,
    S_PAD    = 7'b0000100,
    S_PWAIT  = 7'b0001000,
    S_LEN    = 7'b0010000,
    S_LWAIT  = 7'b0100000,
    S_OUT    = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t state;
  logic [5:0]  fill;
  logic [60:0] total;
  logic        pend_end;
  logic [63:0] bits;
  logic        accept;
  logic [5:0]  fill_inc;
  logic [2:0]  len_sel;

  assign ready    = (state == S_IDLE);
  assign accept   = valid && ready;
  assign fill_inc = fill + 6'd1;
  assign bits     = {total, 3'b000};
  assign out_valid = (state == S_OUT);
  assign last_word = (word_index == 3'd7);
  assign len_sel  = fill[2:0];

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && byte_present) begin
          cmd.write_byte = 1'b1;
          cmd.wr_addr    = fill;
          cmd.wr_data    = data_byte;
          cmd.start_comp = (fill == 6'd63);
        end
      end
      S_WAIT: begin
        // pad marker once the buffer is free
        if (!stat.comp_busy && pend_end) begin
          cmd.write_byte = 1'b1;
          cmd.wr_addr    = fill;
          cmd.wr_data    = 8'h80;
          cmd.start_comp = (fill == 6'd63);
        end
      end
      S_PAD: begin
        cmd.write_byte = 1'b1;
        cmd.wr_addr    = fill;
        cmd.wr_data    = 8'h00;
        cmd.start_comp = (fill == 6'd63);
      end
      S_LEN: begin
        cmd.write_byte = 1'b1;
        cmd.wr_addr    = fill;
        cmd.wr_data    = bits[6'(63 - 8 * len_sel) -: 8];
        cmd.start_comp = (fill == 6'd63);
      end
      S_OUT: begin
        cmd.shift_out = out_ready;
        cmd.load_iv   = out_ready && last_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      total      <= '0;
      pend_end   <= 1'b0;
      word_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && byte_present) begin
            fill     <= fill_inc;
            total    <= total + 61'd1;
            pend_end <= end_of_message;
            if (fill == 6'd63) state <= S_WAIT;
            else if (end_of_message) state <= S_WAIT;
          end else if (accept && end_of_message) begin
            pend_end <= 1'b1;
            state    <= S_WAIT;
          end
        end
        S_WAIT: begin
          // after a full block, or before writing the pad marker
          if (!stat.comp_busy) begin
            if (pend_end) begin
              pend_end <= 1'b0;
              fill     <= fill_inc;
              priority if (fill == 6'd63) state <= S_PWAIT;
              else if (fill == 6'd55) state <= S_LEN;
              else state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PAD: begin
          if (fill == 6'd63) begin
            fill  <= '0;
            state <= S_PWAIT;
          end else if (fill == 6'd55) begin
            fill  <= fill_inc;
            state <= S_LEN;
          end else begin
            fill <= fill_inc;
          end
        end
        S_PWAIT: begin
          if (!stat.comp_busy) state <= S_PAD;
        end
        S_LEN: begin
          fill <= fill_inc;
          if (fill == 6'd63) state <= S_LWAIT;
        end
        S_LWAIT: begin
          if (!stat.comp_busy) begin
            state      <= S_OUT;
            word_index <= '0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            word_index <= word_index + 3'd1;
            if (last_word) begin
              state <= S_IDLE;
              total <= '0;
              fill  <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_len: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> fill == 6'd0) else $error("fill not cleared for output");
  a_len_aligned: assert property (@(posedge clk) disable iff (rst)
    state == S_LEN |-> fill >= 6'd56) else $error("length written early");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    stat.comp_done |-> state == S_WAIT || state == S_PWAIT || state == S_LWAIT)
    else $error("compression finished out of sequence");

endmodule

[rtl/sha256_stream_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// streaming sha-256, at most one byte per input word, digest as eight words
// ----------------------------------------------------------------------------
// channel   signals                                        direction
// input     valid ready data_byte byte_present end_of_message   in
// output    out_valid out_ready digest_word word_index last_word out
//
// a byte that does not fill a block, or an idle word, leaves ready high
// a byte that fills a block holds ready low while the block loads, the rounds
// run, the hash words are added and control hands back
// end of message: the pad marker, zero bytes up to byte 56, eight length
// bytes, then a compression (two if over 55 bytes pend)
// the digest waits as long as out_ready is low; input is held off meanwhile
// rst is synchronous and restores the initial hash values
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha_ctrl u_ctrl (
    .clk, .rst, .valid, .ready, .data_byte, .byte_present, .end_of_message,
    .out_valid, .out_ready, .word_index, .last_word, .cmd, .stat
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .stat, .head_word(digest_word)
  );

endmodule

[tb/sha256_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_checker
// watches both channels of the hasher, computes the expected digest of each
// message from the accepted words and compares every digest word in order
// ----------------------------------------------------------------------------
module sha256_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending
);
  import sha_pkg::*;

  typedef struct packed {
    word_t      dword;
    logic [2:0] idx;
    logic       last;
  } digest_item_t;

  word_t        hash_state [8];
  logic [7:0]   msg_block [64];
  logic [5:0]   fill;
  logic [60:0]  msg_bytes;
  digest_item_t digest_q [$];

  assign pending = digest_q.size();

  function automatic word_t rr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    word_t w [64];
    word_t v [8];
    word_t s0, s1, x1, x2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      x1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
      x2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + x1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = x1 + x2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) hash_state[i] = iv_word(i[2:0]);
    fill = 0;
    msg_bytes = 0;
  endtask

  task automatic absorb(logic [7:0] b, logic has_byte, logic fin);
    logic [63:0] bit_len;
    int i;
    digest_item_t d;
    if (has_byte) begin
      msg_block[fill] = b;
      msg_bytes++;
      if (fill == 63) begin
        compress();
        fill = 0;
      end else begin
        fill++;
      end
    end
    if (!fin) return;
    bit_len = {msg_bytes, 3'b000};
    i = fill;
    msg_block[i] = 8'h80;
    i++;
    if (i > 56) begin
      while (i < 64) msg_block[i++] = 8'h00;
      compress();
      i = 0;
    end
    while (i < 56) msg_block[i++] = 8'h00;
    for (int k = 0; k < 8; k++) msg_block[56+k] = bit_len[63-8*k -: 8];
    compress();
    for (int k = 0; k < 8; k++) begin
      d.dword = hash_state[k];
      d.idx = k[2:0];
      d.last = (k == 7);
      digest_q.push_back(d);
    end
    restart();
  endtask

  initial begin
    fail_count = 0;
    restart();
  end

  always @(posedge clk) begin
    digest_item_t e;
    if (rst) begin
      restart();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("digest word with none expected: %h", digest_word);
          fail_count++;
        end else begin
          e = digest_q.pop_front();
          if (digest_word !== e.dword) begin
            $error("digest_word expected %h actual %h", e.dword, digest_word);
            fail_count++;
          end
          if (word_index !== e.idx) begin
            $error("word_index expected %0d actual %0d", e.idx, word_index);
            fail_count++;
          end
          if (last_word !== e.last) begin
            $error("last_word expected %0d actual %0d", e.last, last_word);
            fail_count++;
          end
        end
      end
      if (valid && ready) absorb(data_byte, byte_present, end_of_message);
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives byte streams and message ends into the hasher with random bursts
// and gaps, stalls the digest side, and reports the checker's verdict
// ----------------------------------------------------------------------------
module testbench;

  logic        clk = 0;
  logic        rst = 1;
  logic        valid = 0;
  logic        ready;
  logic [7:0]  data_byte = 0;
  logic        byte_present = 0;
  logic        end_of_message = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          sent = 0;

  always #1 clk = ~clk;

  sha256_stream_hasher dut (.*);
  sha256_checker checker_i (.*);

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 15);
    if (rst) out_ready <= 0;
    else if (r < 4) out_ready <= 1;
    else if (r < 7) out_ready <= 0;
    else if (r == 7) out_ready <= ~out_ready;
  end

  task automatic send_word(logic [7:0] b, logic has_byte, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    sent++;
    valid <= 1;
    data_byte <= b;
    byte_present <= has_byte;
    end_of_message <= fin;
    @(posedge clk);
    while (!ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int len, logic fin_carries);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 0, 0);
      send_word(8'($urandom), 1, fin_carries && i == len - 1);
    end
    if (!fin_carries || len == 0) send_word(8'($urandom), 0, 1);
  endtask

  initial begin
    int lens [8] = '{0, 1, 55, 56, 57, 63, 64, 3};
    int guard;
    repeat (4) @(negedge clk);
    rst <= 0;
    send_word(8'h00, 0, 0);
    send_word(8'hff, 0, 0);
    send_word(8'h00, 0, 1);
    send_word(8'hff, 1, 0);
    send_word(8'h00, 1, 0);
    send_word(8'haa, 1, 1);
    send_word(8'h55, 1, 1);
    for (int i = 0; i < 8; i++) send_message(lens[i], 1'($urandom_range(0, 1)));
    while (sent < 370) begin
      send_message($urandom_range(0, 20), 1'($urandom_range(0, 1)));
    end
    valid <= 0;
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sha256_stream_hasher test passed");
    end else begin
      $display("sha256_stream_hasher test failed");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("sha256_stream_hasher test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_stream_hasher.sv
tb/sha256_checker.sv
tb/testbench.sv
